### rtl/cpr_pkg.sv
// Shared types, constants and helper functions for the clock page replacement block.
// No dependencies; every other source file uses this package.
package cpr_pkg;

	// Ring geometry and field widths
	localparam int SLOTS     = 64;
	localparam int PAGE_BITS = 32;
	localparam int ID_W      = 32;
	localparam int CFG_W     = 7;
	localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);

	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;

	// Request kinds
	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_MARK   = 1'b1
	} mode_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_EVICT,
		ST_SEARCH,
		ST_RESULT
	} state_t;

	// Operations on the valid/reference flag bank
	typedef enum logic [2:0] {
		FL_NONE,
		FL_CLR_REF,
		FL_SET_REF,
		FL_FILL,
		FL_RESIZE
	} flag_op_t;

	typedef struct packed {
		flag_op_t op;
		slot_t    idx;
		cnt_t     size;
	} flag_cmd_t;

	// Page store access
	typedef struct packed {
		logic  re;
		slot_t raddr;
		logic  we;
		slot_t waddr;
		page_t wdata;
	} ram_req_t;

	// One result item
	typedef struct packed {
		logic            evicted_valid;
		logic [ID_W-1:0] evicted_page;
	} result_t;

	// Effective ring size: zero acts as one, oversize clamps to the slot count
	function automatic cnt_t ring_size(input logic [CFG_W-1:0] v);
		cnt_t r;
		if (v == '0)
			r = CNT_W'(1);
		else if (int'(v) > SLOTS)
			r = CNT_W'(SLOTS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	// Hand advance with wrap at the ring size
	function automatic slot_t next_slot(input slot_t h, input cnt_t size);
		cnt_t n;
		n = CNT_W'(h) + CNT_W'(1);
		return (n >= size) ? '0 : n[SLOT_W-1:0];
	endfunction

endpackage

### rtl/cpr_if.sv
// Handshake channel interfaces: request, result and size configuration.
// Depends on cpr_pkg for field widths.
interface cpr_req_if;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic [cpr_pkg::ID_W-1:0] page_id;

	modport source (output valid, output mode, output page_id, input ready);
	modport sink   (input valid, input mode, input page_id, output ready);
endinterface

interface cpr_rsp_if;
	logic                     valid;
	logic                     ready;
	logic                     evicted_valid;
	logic [cpr_pkg::ID_W-1:0] evicted_page;

	modport source (output valid, output evicted_valid, output evicted_page, input ready);
	modport sink   (input valid, input evicted_valid, input evicted_page, output ready);
endinterface

interface cpr_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [cpr_pkg::CFG_W-1:0] slots_in_use;

	modport source (output valid, output slots_in_use, input ready);
	modport sink   (input valid, input slots_in_use, output ready);
endinterface

### rtl/cpr_page_ram.sv
// Page identifier store: one write port, one read port, registered read data.
// Depends on cpr_pkg for geometry and the access struct.
module cpr_page_ram (
	input  logic              clk,
	input  cpr_pkg::ram_req_t req,
	output cpr_pkg::page_t    rdata
);
	import cpr_pkg::*;

	page_t mem [SLOTS];
	page_t rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (req.re)
			rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/cpr_slot_flags.sv
// Per-slot valid and reference marks, cleared at reset and trimmed on resize.
// Depends on cpr_pkg for the flag command struct.
module cpr_slot_flags (
	input  logic               clk,
	input  logic               arst_n,
	input  cpr_pkg::flag_cmd_t cmd,
	output logic [cpr_pkg::SLOTS-1:0] slot_valid,
	output logic [cpr_pkg::SLOTS-1:0] slot_ref
);
	import cpr_pkg::*;

	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] ref_q;

	// Flag updates, one command per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
		end else begin
			unique case (cmd.op)
				FL_NONE: ;
				FL_CLR_REF: ref_q[cmd.idx] <= 1'b0;
				FL_SET_REF: ref_q[cmd.idx] <= 1'b1;
				FL_FILL: begin
					valid_q[cmd.idx] <= 1'b1;
					ref_q[cmd.idx]   <= 1'b0;
				end
				FL_RESIZE: begin
					// slots leaving the ring become empty
					for (int i = 0; i < SLOTS; i++) begin
						if (CNT_W'(i) >= cmd.size) begin
							valid_q[i] <= 1'b0;
							ref_q[i]   <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign slot_valid = valid_q;
	assign slot_ref   = ref_q;

endmodule

### rtl/cpr_ctrl.sv
// Sequencer: hand sweep for inserts, page search for mark-used, size register.
// Depends on cpr_pkg and the channel interfaces; drives the flag bank and the page store through its ports.
module cpr_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	cpr_req_if.sink                   req,
	cpr_cfg_if.sink                   cfg,
	input  logic [cpr_pkg::SLOTS-1:0] slot_valid,
	input  logic [cpr_pkg::SLOTS-1:0] slot_ref,
	output cpr_pkg::flag_cmd_t        flag_cmd,
	output cpr_pkg::ram_req_t         ram_req,
	input  cpr_pkg::page_t            ram_rdata,
	output logic                      res_valid,
	input  logic                      res_ready,
	output cpr_pkg::result_t          res
);
	import cpr_pkg::*;

	state_t  state_q, state_d;
	cnt_t    size_q;
	slot_t   hand_q;
	slot_t   h_q;
	cnt_t    idx_q;
	page_t   page_q;
	logic    chk_s1;
	slot_t   addr_s1;
	result_t res_q;

	logic    accept;
	logic    cfg_wr;
	cnt_t    cfg_size;
	logic    sweep_ref;
	logic    hit;
	logic    search_more;

	assign accept      = req.valid && req.ready;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign cfg_size    = ring_size(cfg.slots_in_use);
	assign sweep_ref   = slot_valid[h_q] && slot_ref[h_q];
	assign hit         = chk_s1 && slot_valid[addr_s1] && (ram_rdata == page_q);
	assign search_more = idx_q < size_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid)
					state_d = (req.mode == MODE_MARK) ? ST_SEARCH : ST_SWEEP;
			end
			ST_SWEEP: begin
				if (!sweep_ref)
					state_d = ST_EVICT;
			end
			ST_EVICT: state_d = ST_RESULT;
			ST_SEARCH: begin
				if (hit || (!chk_s1 && !search_more))
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (res_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: handshakes, flag commands, store accesses
	always_comb begin
		req.ready     = (state_q == ST_IDLE);
		cfg.ready     = 1'b1;
		res_valid     = (state_q == ST_RESULT);
		flag_cmd.op   = FL_NONE;
		flag_cmd.idx  = h_q;
		flag_cmd.size = cfg_size;
		ram_req.re    = 1'b0;
		ram_req.raddr = h_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = h_q;
		ram_req.wdata = page_q;
		priority if (cfg_wr) begin
			flag_cmd.op = FL_RESIZE;
		end else if (state_q == ST_SWEEP) begin
			if (sweep_ref)
				flag_cmd.op = FL_CLR_REF;
			else
				ram_req.re = 1'b1;
		end else if (state_q == ST_EVICT) begin
			flag_cmd.op = FL_FILL;
			ram_req.we  = 1'b1;
		end else if (state_q == ST_SEARCH) begin
			if (hit) begin
				flag_cmd.op  = FL_SET_REF;
				flag_cmd.idx = addr_s1;
			end
			ram_req.re    = search_more;
			ram_req.raddr = idx_q[SLOT_W-1:0];
		end else begin
			// idle or waiting on the result: no access
			flag_cmd.op = FL_NONE;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= CNT_W'(SLOTS);
			hand_q  <= '0;
			chk_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				size_q <= cfg_size;
				if (CNT_W'(hand_q) >= cfg_size)
					hand_q <= '0;
			end
			if (state_q == ST_EVICT)
				hand_q <= next_slot(h_q, size_q);
			if (state_q == ST_SEARCH)
				chk_s1 <= search_more;
			else
				chk_s1 <= 1'b0;
		end
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= PAGE_BITS'(req.page_id);
			h_q    <= (CNT_W'(hand_q) >= size_q) ? '0 : hand_q;
			idx_q  <= '0;
		end
		if (state_q == ST_SWEEP && sweep_ref)
			h_q <= next_slot(h_q, size_q);
		if (state_q == ST_SEARCH) begin
			res_q <= '0;
			if (search_more) begin
				idx_q   <= idx_q + CNT_W'(1);
				addr_s1 <= idx_q[SLOT_W-1:0];
			end
		end
		if (state_q == ST_EVICT) begin
			res_q.evicted_valid <= slot_valid[h_q];
			res_q.evicted_page  <= slot_valid[h_q] ? ID_W'(ram_rdata) : '0;
		end
	end

	assign res = res_q;

endmodule

### rtl/clock_page_replacement.sv
// Clock (second-chance) page replacement over a ring of up to 64 slots, one item at a
// time. An insert walks the hand over the flag bank one slot per cycle, clearing the
// reference mark of each valid referenced slot it passes, and then reads and rewrites
// the page store at the first slot that is empty or unreferenced. A mark-used search
// reads the page store one slot per cycle and stops at the first valid match. Either
// kind of item waits in its result state while the output register still holds an
// earlier result the receiver has not taken. A finished result sits in an output
// register, so the next request is taken while it waits. The ring size register may be
// written only while no request is in flight; there is no clearing pass after reset.
module clock_page_replacement (
	input  logic      clk,
	input  logic      arst_n,
	cpr_req_if.sink   req,
	cpr_rsp_if.source rsp,
	cpr_cfg_if.sink   cfg
);
	import cpr_pkg::*;

	logic [SLOTS-1:0] slot_valid;
	logic [SLOTS-1:0] slot_ref;
	flag_cmd_t        flag_cmd;
	ram_req_t         ram_req;
	page_t            ram_rdata;
	logic             res_valid;
	logic             res_ready;
	result_t          res;

	logic             out_valid_q;
	result_t          out_q;

	cpr_slot_flags u_flags (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (flag_cmd),
		.slot_valid (slot_valid),
		.slot_ref   (slot_ref)
	);

	cpr_page_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	cpr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.slot_valid (slot_valid),
		.slot_ref   (slot_ref),
		.flag_cmd   (flag_cmd),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Output register
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.evicted_valid = out_q.evicted_valid;
	assign rsp.evicted_page  = out_q.evicted_page;

endmodule

### rtl/cpr_checker.sv
// Port-level checks for the clock page replacement block, and the bind that attaches them.
// Depends on cpr_pkg for field widths.
module cpr_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     out_ev,
	input logic [cpr_pkg::ID_W-1:0] out_page
);
	import cpr_pkg::*;

	// One request at a time: no back-to-back transfers
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while previous one in flight");

	// No result can appear the cycle after a request transfer
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// A result without eviction carries a zero page
	a_zero_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ev |-> out_page == '0)
		else $error("non-zero page without eviction");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_ev) && $stable(out_page))
		else $error("stalled result changed");

endmodule

bind clock_page_replacement cpr_checker u_cpr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_ev    (rsp.evicted_valid),
	.out_page  (rsp.evicted_page)
);

### tb/clock_page_replacement_tb.sv
// Self-checking testbench for the clock (second-chance) page replacement block.
// Depends on cpr_pkg, the channel interfaces in cpr_if.sv and clock_page_replacement.
// Has its own model of the ring, runs directed and random items, and adds random stalls.
module clock_page_replacement_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cpr_pkg::*;

	logic clk;
	logic arst_n;

	cpr_req_if req_ch ();
	cpr_rsp_if rsp_ch ();
	cpr_cfg_if cfg_ch ();

	clock_page_replacement i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Model of the ring
	bit [SLOTS-1:0]   ring_valid;
	bit [SLOTS-1:0]   ring_ref;
	page_t            ring_page [SLOTS];
	slot_t            ring_hand;
	logic [CFG_W-1:0] ring_size_reg;

	result_t expected_evictions [$];
	page_t   page_pool [16];
	int      mismatches;
	bit      idle_on;
	int      hold_cycles;

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Effective ring length: zero acts as one, oversize is clamped
	function automatic int ring_len();
		int n;
		n = int'(ring_size_reg);
		if (n == 0)
			n = 1;
		else if (n > SLOTS)
			n = SLOTS;
		return n;
	endfunction

	function automatic void reset_ring();
		ring_valid    = '0;
		ring_ref      = '0;
		ring_hand     = '0;
		ring_size_reg = CFG_W'(SLOTS);
		foreach (ring_page[i])
			ring_page[i] = '0;
	endfunction

	// Size write: slots leaving the ring become empty, a hand past the new end wraps to slot 0
	function automatic void resize_ring(logic [CFG_W-1:0] v);
		int n;
		ring_size_reg = v;
		n = ring_len();
		for (int i = n; i < SLOTS; i++) begin
			ring_valid[i] = 1'b0;
			ring_ref[i]   = 1'b0;
		end
		if (int'(ring_hand) >= n)
			ring_hand = '0;
	endfunction

	// Apply one item to the ring and return the eviction it reports
	function automatic result_t predict_eviction(mode_t m, page_t p);
		result_t r;
		int      n;
		int      h;
		r = '0;
		n = ring_len();
		if (m == MODE_MARK) begin
			for (int i = 0; i < n; i++) begin
				if (ring_valid[i] && ring_page[i] == p) begin
					ring_ref[i] = 1'b1;
					break;
				end
			end
		end else begin
			h = int'(ring_hand);
			if (h >= n)
				h = 0;
			// second chance: clear marks of referenced pages on the way
			while (ring_valid[h] && ring_ref[h]) begin
				ring_ref[h] = 1'b0;
				h = (h + 1 >= n) ? 0 : h + 1;
			end
			if (ring_valid[h]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page  = ring_page[h];
			end
			ring_valid[h] = 1'b1;
			ring_ref[h]   = 1'b0;
			ring_page[h]  = p;
			ring_hand     = slot_t'((h + 1 >= n) ? 0 : h + 1);
		end
		return r;
	endfunction

	// Send one request; valid stays high afterwards unless the next call idles
	task automatic send_item(mode_t m, page_t p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.mode    <= m;
		req_ch.page_id <= p;
		do @(posedge clk); while (!req_ch.ready);
		expected_evictions.push_back(predict_eviction(m, p));
	endtask

	// Stop requesting and wait until every result has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (expected_evictions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ring_size(logic [CFG_W-1:0] v);
		drain_results();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.slots_in_use <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		resize_ring(v);
		cfg_ch.valid <= 1'b0;
	endtask

	// Random item: mostly pages from a small pool so that marks hit and pages repeat
	task automatic send_random_item();
		mode_t m;
		page_t p;
		int    k;
		m = $urandom_range(0, 1) ? MODE_MARK : MODE_INSERT;
		k = $urandom_range(0, 15);
		if ($urandom_range(0, 9) < ((m == MODE_MARK) ? 8 : 6)) begin
			p = page_pool[k];
		end else begin
			p = $urandom();
			if (m == MODE_INSERT)
				page_pool[k] = p;
		end
		send_item(m, p);
	endtask

	task automatic send_random_items(int count);
		repeat (count) send_random_item();
	endtask

	// Result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_evictions.size() == 0) begin
				$error("unexpected result transfer: evicted_valid %0b evicted_page %h",
					rsp_ch.evicted_valid, rsp_ch.evicted_page);
				mismatches++;
			end else begin
				want = expected_evictions.pop_front();
				if (rsp_ch.evicted_valid !== want.evicted_valid) begin
					$error("evicted_valid: expected %0b, actual %0b",
						want.evicted_valid, rsp_ch.evicted_valid);
					mismatches++;
				end
				if (rsp_ch.evicted_page !== want.evicted_page) begin
					$error("evicted_page: expected %h, actual %h",
						want.evicted_page, rsp_ch.evicted_page);
					mismatches++;
				end
			end
		end
	end

	// Result receiver: random stall bursts, plus a long hold-off on request
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 8);
				rsp_ch.ready <= 1'b0;
			end else begin
				n = 1;
				rsp_ch.ready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// Extreme page ids, hit and miss marks, duplicate insert
	task automatic test_basic_ops();
		send_item(MODE_INSERT, 32'h0000_0000);
		send_item(MODE_INSERT, 32'hFFFF_FFFF);
		send_item(MODE_INSERT, 32'hA5A5_5A5A);
		send_item(MODE_MARK, 32'h0000_0000);
		send_item(MODE_MARK, 32'hDEAD_BEEF);
		send_item(MODE_INSERT, 32'h0000_0000);
		send_item(MODE_MARK, 32'hFFFF_FFFF);
	endtask

	// Referenced pages survive one pass of the hand
	task automatic test_second_chance();
		write_ring_size(CFG_W'(4));
		for (int i = 0; i < 4; i++)
			send_item(MODE_INSERT, page_t'(32'h10 + i));
		send_item(MODE_MARK, 32'h11);
		send_item(MODE_MARK, 32'h10);
		send_item(MODE_INSERT, 32'h14);
		send_item(MODE_INSERT, 32'h15);
	endtask

	// Size of zero, oversize, and a shrink with the hand past the new end
	task automatic test_size_limits();
		write_ring_size(CFG_W'(0));
		send_item(MODE_INSERT, 32'h1);
		send_item(MODE_INSERT, 32'h2);
		send_item(MODE_MARK, 32'h2);
		write_ring_size(CFG_W'(127));
		send_item(MODE_INSERT, 32'h3);
		write_ring_size(CFG_W'(8));
		for (int i = 0; i < 5; i++)
			send_item(MODE_INSERT, page_t'(32'h20 + i));
		write_ring_size(CFG_W'(3));
		send_item(MODE_INSERT, 32'h30);
	endtask

	// Random phases over several ring sizes
	task automatic test_random_phases();
		logic [CFG_W-1:0] sizes [7];
		sizes = '{CFG_W'(1), CFG_W'(65), CFG_W'(2), CFG_W'(7), CFG_W'(64), '0, '0};
		sizes[5] = CFG_W'($urandom_range(0, 127));
		sizes[6] = CFG_W'($urandom_range(1, 16));
		foreach (page_pool[i])
			page_pool[i] = $urandom();
		for (int ph = 0; ph < 7; ph++) begin
			write_ring_size(sizes[ph]);
			idle_on = (ph != 3);
			send_random_items(200);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming
	task automatic test_backpressure();
		write_ring_size(CFG_W'(5));
		idle_on = 1'b0;
		hold_cycles = 300;
		send_random_items(20);
	endtask

	task automatic test_full_rate();
		write_ring_size(CFG_W'($urandom_range(1, 64)));
		idle_on = 1'b0;
		send_random_items(200);
	endtask

	initial begin
		mismatches  = 0;
		idle_on     = 1'b1;
		hold_cycles = 0;
		reset_ring();
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.mode         <= MODE_INSERT;
		req_ch.page_id      <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.slots_in_use <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_second_chance();
		test_size_limits();
		test_random_phases();
		test_backpressure();
		test_full_rate();

		drain_results();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
rtl/cpr_pkg.sv
rtl/cpr_if.sv
rtl/cpr_page_ram.sv
rtl/cpr_slot_flags.sv
rtl/cpr_ctrl.sv
rtl/clock_page_replacement.sv
rtl/cpr_checker.sv
tb/clock_page_replacement_tb.sv
